### rtl/core/pidt_pkg.sv
// Shared types, constants and the sequencer microcode for the timestamped PID block.
`default_nettype none
package pidt_pkg;

  localparam int PC_W = 4;

  // Config register indexes (byte address / 4)
  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KI = 2'd1;
  localparam logic [1:0] REG_KD = 2'd2;

  localparam logic signed [63:0] INT48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] INT48_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;
  localparam logic signed [63:0] INT32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] INT32_MIN = -64'sh0000_0000_7FFF_FFFF - 64'sd1;

  localparam logic [31:0] DT_DIVISOR = 32'd10;

  // Program steps
  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_MUL_P    = 4'd1;
  localparam logic [PC_W-1:0] S_MUL_KIE  = 4'd2;
  localparam logic [PC_W-1:0] S_MUL_KIET = 4'd3;
  localparam logic [PC_W-1:0] S_DIV_I    = 4'd4;
  localparam logic [PC_W-1:0] S_WAIT_I   = 4'd5;
  localparam logic [PC_W-1:0] S_UPD_I    = 4'd6;
  localparam logic [PC_W-1:0] S_MUL_D10  = 4'd7;
  localparam logic [PC_W-1:0] S_DIV_D    = 4'd8;
  localparam logic [PC_W-1:0] S_WAIT_D   = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT     = 4'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_ERR,
    MUL_KI_ERR,
    MUL_PROD_ELAPSED,
    MUL_KD_DIFF,
    MUL_PROD_TEN
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_BY_TEN,
    DIV_BY_ELAPSED
  } div_sel_t;

  typedef struct packed {
    mul_sel_t        mul_sel;
    div_sel_t        div_sel;
    logic            wait_in;
    logic            wait_div;
    logic            lat_p;
    logic            upd_int;
    logic            emit;
    logic            jmp;
    logic            jmp_zero;
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  function automatic ctrl_t pidt_ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{mul_sel: MUL_NONE, div_sel: DIV_NONE, wait_in: 1'b0, wait_div: 1'b0,
          lat_p: 1'b0, upd_int: 1'b0, emit: 1'b0, jmp: 1'b0, jmp_zero: 1'b0,
          tgt: S_IDLE};
    case (pc)
      S_IDLE:     c.wait_in = 1'b1;
      S_MUL_P:    c.mul_sel = MUL_KP_ERR;
      S_MUL_KIE: begin
        c.lat_p   = 1'b1;
        c.mul_sel = MUL_KI_ERR;
      end
      S_MUL_KIET: c.mul_sel = MUL_PROD_ELAPSED;
      S_DIV_I:    c.div_sel = DIV_BY_TEN;
      S_WAIT_I:   c.wait_div = 1'b1;
      S_UPD_I: begin
        c.upd_int = 1'b1;
        c.mul_sel = MUL_KD_DIFF;
      end
      S_MUL_D10:  c.mul_sel = MUL_PROD_TEN;
      S_DIV_D: begin
        c.div_sel  = DIV_BY_ELAPSED;
        c.jmp_zero = 1'b1;
        c.tgt      = S_EMIT;
      end
      S_WAIT_D:   c.wait_div = 1'b1;
      S_EMIT: begin
        c.emit = 1'b1;
        c.jmp  = 1'b1;
        c.tgt  = S_IDLE;
      end
      default: begin
        c.jmp = 1'b1;
        c.tgt = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/pidt_div.sv
// Iterative signed divider, one quotient bit per cycle or 16 per cycle by ten, truncates to zero.
`default_nettype none
module pidt_div
  import pidt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               by_ten,
  input  wire logic signed [63:0] num,
  input  wire logic [31:0]        den,
  output logic                    busy,
  output logic signed [63:0]      quot
);

  localparam logic [6:0]  NUM_ITER  = 7'd64;
  localparam logic [6:0]  TEN_STEPS = 7'd4;
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  logic        busy_r, busy_nxt;
  logic        ten_mode_r, ten_mode_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;
  logic [19:0] ten_v;
  logic [50:0] ten_prod;
  logic [15:0] ten_q;
  logic [19:0] ten_back;

  assign shifted = {rem_r, num_r[63]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  // base 2^16 long division by ten; the reciprocal multiply is exact for values below 2^32
  assign ten_v    = {rem_r[3:0], num_r[63:48]};
  assign ten_prod = 51'(ten_v) * 51'(RECIP_TEN);
  assign ten_q    = ten_prod[50:35];
  assign ten_back = ten_v - ({1'b0, ten_q, 3'b000} + {3'b000, ten_q, 1'b0});

  always_comb begin
    busy_nxt     = busy_r;
    ten_mode_nxt = ten_mode_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    den_nxt      = den_r;
    if (start) begin
      busy_nxt     = 1'b1;
      ten_mode_nxt = by_ten;
      cnt_nxt      = by_ten ? TEN_STEPS : NUM_ITER;
      neg_nxt      = num[63];
      num_nxt      = num[63] ? 64'(-num) : 64'(num);
      rem_nxt      = '0;
      den_nxt      = den;
    end else if (busy_r) begin
      if (cnt_r != 7'd0) begin
        cnt_nxt = cnt_r - 7'd1;
        if (ten_mode_r) begin
          num_nxt = {num_r[47:0], ten_q};
          rem_nxt = {28'd0, ten_back[3:0]};
        end else begin
          num_nxt = {num_r[62:0], ge};
          rem_nxt = ge ? diff[31:0] : shifted[31:0];
        end
      end else begin
        // restore the sign of the quotient
        busy_nxt = 1'b0;
        num_nxt  = neg_r ? (~num_r + 64'd1) : num_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    ten_mode_r <= ten_mode_nxt;
    neg_r      <= neg_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = signed'(num_r);

endmodule
`default_nettype wire

### rtl/core/pid_controller_timestamped.sv
// Top level of the timestamped PID controller: microcode sequencer, shared multiplier, divider.
// Each input transaction carries a Q8.8 error and a millisecond timestamp and yields one
// saturated Q16.16 P+I+D value; out_tuser is set when the timestamp equals the last one and the
// derivative was dropped. The sequencer returns to idle as the result is registered and then
// takes the next input. The derivative divide by the elapsed time yields one quotient bit per
// cycle. The integral divide by 10 runs four 16-bit reciprocal steps and a sign step. A stalled
// output holds the sequencer at the emit step. A new input is taken while the previous result
// still waits in the output register. Gains are written through the APB port at byte addresses
// 0 (Kp), 4 (Ki) and 8 (Kd); the user must write them only while idle, which the block itself
// does not enforce.
`default_nettype none
module pid_controller_timestamped
  import pidt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [15:0] error_sample, [47:16] timestamp_ms
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] control_out
  output logic             out_tuser,  // [0] zero_interval
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  ctrl_t                   ctrl;
  logic [PC_W-1:0]         pc_r, pc_nxt;

  logic signed [15:0]      kp_r, ki_r, kd_r;
  logic signed [15:0]      err_r, last_err_r;
  logic [31:0]             stamp_r, last_stamp_r, elapsed_r;
  logic                    zero_r;
  logic signed [63:0]      prod_r;
  logic signed [31:0]      p_r;
  logic signed [47:0]      int_r;
  logic                    out_valid_r;
  logic signed [31:0]      out_data_r;
  logic                    out_user_r;

  logic                    in_fire, cfg_wr, emit_fire, out_blocked;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      mul_full;
  logic signed [16:0]      err_diff;
  logic                    div_start, div_busy, div_by_ten;
  logic signed [63:0]      div_num, div_quot;
  logic [31:0]             div_den;
  logic signed [63:0]      int_sum, deriv, total;
  logic signed [47:0]      int_nxt;
  logic signed [31:0]      ctl_nxt;

  assign ctrl = pidt_ucode(pc_r);

  assign in_tready   = (pc_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign out_blocked = out_valid_r && !out_tready;
  assign emit_fire   = ctrl.emit && !out_blocked;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready  = 1'b1;

  // Sequencer next step
  always_comb begin
    if (ctrl.wait_in && !in_fire) begin
      pc_nxt = pc_r;
    end else if (ctrl.wait_div && div_busy) begin
      pc_nxt = pc_r;
    end else if (ctrl.emit && out_blocked) begin
      pc_nxt = pc_r;
    end else if (ctrl.jmp || (ctrl.jmp_zero && zero_r)) begin
      pc_nxt = ctrl.tgt;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  // Shared multiplier operands
  assign err_diff = 17'(err_r) - 17'(last_err_r);

  always_comb begin
    case (ctrl.mul_sel)
      MUL_KP_ERR: begin
        mul_a = 33'(kp_r);
        mul_b = 33'(err_r);
      end
      MUL_KI_ERR: begin
        mul_a = 33'(ki_r);
        mul_b = 33'(err_r);
      end
      MUL_PROD_ELAPSED: begin
        mul_a = prod_r[32:0];
        mul_b = signed'({1'b0, elapsed_r});
      end
      MUL_KD_DIFF: begin
        mul_a = 33'(kd_r);
        mul_b = 33'(err_diff);
      end
      MUL_PROD_TEN: begin
        mul_a = prod_r[32:0];
        mul_b = signed'({1'b0, DT_DIVISOR});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Divider hookup; the derivative divide is skipped when no time elapsed
  assign div_start  = (ctrl.div_sel != DIV_NONE) && !(ctrl.jmp_zero && zero_r);
  assign div_by_ten = (ctrl.div_sel == DIV_BY_TEN);
  assign div_num    = prod_r;

  always_comb begin
    case (ctrl.div_sel)
      DIV_BY_TEN:     div_den = DT_DIVISOR;
      DIV_BY_ELAPSED: div_den = elapsed_r;
      default:        div_den = DT_DIVISOR;
    endcase
  end

  pidt_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .by_ten (div_by_ten),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .quot   (div_quot)
  );

  // Integral saturation to 48 bits
  always_comb begin
    int_sum = 64'(int_r) + div_quot;
    if (int_sum > INT48_MAX) begin
      int_nxt = INT48_MAX[47:0];
    end else if (int_sum < INT48_MIN) begin
      int_nxt = INT48_MIN[47:0];
    end else begin
      int_nxt = int_sum[47:0];
    end
  end

  // Output sum and saturation to Q16.16
  always_comb begin
    deriv = zero_r ? 64'sd0 : div_quot;
    total = 64'(p_r) + 64'(int_r) + deriv;
    if (total > INT32_MAX) begin
      ctl_nxt = INT32_MAX[31:0];
    end else if (total < INT32_MIN) begin
      ctl_nxt = INT32_MIN[31:0];
    end else begin
      ctl_nxt = total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_IDLE;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      int_r        <= '0;
      last_err_r   <= '0;
      last_stamp_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_KP:  kp_r <= cfg_pwdata[15:0];
          REG_KI:  ki_r <= cfg_pwdata[15:0];
          REG_KD:  kd_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (ctrl.upd_int) begin
        int_r <= int_nxt;
      end
      if (emit_fire) begin
        last_err_r   <= err_r;
        last_stamp_r <= stamp_r;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r     <= in_tdata[15:0];
      stamp_r   <= in_tdata[47:16];
      elapsed_r <= in_tdata[47:16] - last_stamp_r;
      zero_r    <= (in_tdata[47:16] == last_stamp_r);
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_r <= mul_full[63:0];
    end
    if (ctrl.lat_p) begin
      p_r <= prod_r[31:0];
    end
    if (emit_fire) begin
      out_data_r <= ctl_nxt;
      out_user_r <= zero_r;
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_KP:  cfg_prdata = 32'(kp_r);
      REG_KI:  cfg_prdata = 32'(ki_r);
      REG_KD:  cfg_prdata = 32'(kd_r);
      default: cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The divider is always quiet while waiting for input
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  // An accepted item starts the program
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == S_MUL_P))
    else $error("sequencer did not start after accept");

  // Zero elapsed time skips the derivative divide
  a_zero_skips_div: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_DIV_D && zero_r) |=> (pc_r == S_EMIT && !div_busy))
    else $error("derivative divide not skipped on zero interval");

  // A result is only written when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending output");

  // A written result shows up as valid next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (out_tvalid && pc_r == S_IDLE))
    else $error("result not presented after emit");

endmodule
`default_nettype wire
